// File: rtl/dlts_pkg.sv
// Shared types and constants for the delta-list task scheduler.
// No dependencies; every other rtl file but dlts_ram refers to it by scoped names.
package dlts_pkg;

    // Default list capacity
    localparam int DEFAULT_MAX_TASKS = 16;

    // Pending-run counter saturates here
    localparam logic [7:0] PENDING_MAX = 8'hFF;

    // Request codes
    localparam logic [1:0] REQ_TICK     = 2'd0;
    localparam logic [1:0] REQ_ADD      = 2'd1;
    localparam logic [1:0] REQ_DISPATCH = 2'd2;

    // Input item
    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  task_ident;
        logic [31:0] first_delay;
        logic [31:0] repeat_period;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic        fired;
        logic [7:0]  fired_task;
        logic [3:0]  insert_index;
        logic        status;
        logic [4:0]  entries_used;
    } out_item_t;

    // One list entry as stored in the slot memory
    typedef struct packed {
        logic [7:0]  tid;
        logic [31:0] delay;
        logic [31:0] period;
        logic [7:0]  pending;
    } entry_t;

    // Read address select
    typedef enum logic [2:0] {
        RD_ZERO,
        RD_POS,
        RD_KM1,
        RD_KM2,
        RD_KP1,
        RD_KP2
    } rd_sel_t;

    // Write address/data select
    typedef enum logic [1:0] {
        WR_TICK,
        WR_SHIFT,
        WR_MOVE,
        WR_NEW
    } wr_sel_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    pos_clr;
        logic    walk_step;
        logic    k_load;
        logic    k_clr;
        logic    k_dec;
        logic    k_inc;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    set_full;
        logic    set_index;
        logic    fire;
        logic    out_load;
    } dlts_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic [1:0] req;
        logic       cnt_zero;
        logic       full;
        logic       walk_end;
        logic       walk_go;
        logic       k_above_pos;
        logic       k_above_pos1;
        logic       rm_more;
        logic       rm_more2;
        logic       pending_nz;
        logic       per_nz;
        logic       out_free;
    } dlts_stat_t;

endpackage

// File: rtl/dlts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dlts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; holds its data when idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/dlts_ctrl.sv
// Sequencing state machine for the scheduler: decodes items, walks,
// shifts and removes list entries by commanding the datapath. Uses dlts_pkg.
module dlts_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  dlts_pkg::dlts_stat_t  stat,
    output dlts_pkg::dlts_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TICK_WR,
        S_WALK_RD,
        S_WALK_CMP,
        S_SH_TEST,
        S_SH_WR,
        S_INS_WR,
        S_DISP_CHK,
        S_RM_TEST,
        S_RM_WR,
        S_REINS,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.req)
                    dlts_pkg::REQ_TICK:
                    begin
                        if (stat.cnt_zero)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = dlts_pkg::RD_ZERO;
                            state_next = S_TICK_WR;
                        end
                    end
                    dlts_pkg::REQ_ADD:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_full = 1'b1;
                            state_next   = S_FINISH;
                        end
                        else
                        begin
                            cmd.pos_clr = 1'b1;
                            state_next  = S_WALK_RD;
                        end
                    end
                    dlts_pkg::REQ_DISPATCH:
                    begin
                        if (stat.cnt_zero)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = dlts_pkg::RD_ZERO;
                            state_next = S_DISP_CHK;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_TICK_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = dlts_pkg::WR_TICK;
                state_next = S_FINISH;
            end
            // Walk: fetch entry at pos, then compare against remaining delay
            S_WALK_RD:
            begin
                if (stat.walk_end)
                begin
                    cmd.k_load = 1'b1;
                    state_next = S_SH_TEST;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = dlts_pkg::RD_POS;
                    state_next = S_WALK_CMP;
                end
            end
            S_WALK_CMP:
            begin
                if (stat.walk_go)
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = S_WALK_RD;
                end
                else
                begin
                    cmd.k_load = 1'b1;
                    state_next = S_SH_TEST;
                end
            end
            // Shift tail up by one, top entry first
            S_SH_TEST:
            begin
                if (stat.k_above_pos)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = dlts_pkg::RD_KM1;
                    state_next = S_SH_WR;
                end
                else
                begin
                    state_next = S_INS_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = dlts_pkg::WR_SHIFT;
                cmd.k_dec  = 1'b1;
                if (stat.k_above_pos1)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = dlts_pkg::RD_KM2;
                end
                else
                begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_sel    = dlts_pkg::WR_NEW;
                cmd.cnt_inc   = 1'b1;
                cmd.set_index = (stat.req == dlts_pkg::REQ_ADD);
                state_next    = S_FINISH;
            end
            S_DISP_CHK:
            begin
                if (stat.pending_nz)
                begin
                    cmd.fire   = 1'b1;
                    cmd.k_clr  = 1'b1;
                    state_next = S_RM_TEST;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            // Remove head: move entries down by one
            S_RM_TEST:
            begin
                if (stat.rm_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = dlts_pkg::RD_KP1;
                    state_next = S_RM_WR;
                end
                else
                begin
                    state_next = S_REINS;
                end
            end
            S_RM_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = dlts_pkg::WR_MOVE;
                cmd.k_inc  = 1'b1;
                if (stat.rm_more2)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = dlts_pkg::RD_KP2;
                end
                else
                begin
                    state_next = S_REINS;
                end
            end
            // Drop the head; periodic task goes back in through the walk
            S_REINS:
            begin
                cmd.cnt_dec = 1'b1;
                if (stat.per_nz)
                begin
                    cmd.pos_clr = 1'b1;
                    state_next  = S_WALK_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // A new item is only taken when the controller is idle
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == S_IDLE))
        else $error("item loaded outside idle");

    // Every accepted item leads to decode next cycle
    a_load_decode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_DECODE))
        else $error("decode did not follow load");

    // A write and a result load never coincide
    a_wr_out: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_en && cmd.out_load))
        else $error("memory write during result load");
`endif

endmodule

// File: rtl/dlts_dpath.sv
// Datapath of the scheduler: slot memory, list pointers, count, working
// registers and output register. Uses dlts_pkg and dlts_ram.
module dlts_dpath #(
    parameter int MAX_TASKS = dlts_pkg::DEFAULT_MAX_TASKS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dlts_pkg::in_item_t    in_data,
    input  dlts_pkg::dlts_cmd_t   cmd,
    output dlts_pkg::dlts_stat_t  stat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output dlts_pkg::out_item_t   out_data
);

    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int AW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int EW    = $bits(dlts_pkg::entry_t);

    // Control counters
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] pos_reg;
    logic [CNT_W-1:0] k_reg;
    logic             out_valid_reg;

    // Working registers
    logic [1:0]          req_reg;
    logic [7:0]          task_reg;
    logic [31:0]         rem_reg;
    logic [31:0]         per_reg;
    logic                fired_reg;
    logic [7:0]          ftask_reg;
    logic [3:0]          idx_reg;
    logic                status_reg;
    dlts_pkg::out_item_t out_data_reg;

    // Memory interface
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    dlts_pkg::entry_t wr_entry;
    logic [AW-1:0]    rd_addr;
    logic [EW-1:0]    rd_bits;
    dlts_pkg::entry_t rd_entry;

    // Derived pointers
    logic [CNT_W-1:0] k_m1;
    logic [CNT_W-1:0] k_m2;
    logic [CNT_W-1:0] k_p1;
    logic [CNT_W-1:0] k_p2;
    logic [CNT_W-1:0] pos_p1;
    logic [CNT_W+4:0] cnt_ext;
    logic [CNT_W+3:0] pos_ext;

    dlts_pkg::entry_t tick_entry;
    dlts_pkg::entry_t sh_entry;
    dlts_pkg::entry_t new_entry;

    assign rd_entry = dlts_pkg::entry_t'(rd_bits);

    assign k_m1    = k_reg - CNT_W'(1);
    assign k_m2    = k_reg - CNT_W'(2);
    assign k_p1    = k_reg + CNT_W'(1);
    assign k_p2    = k_reg + CNT_W'(2);
    assign pos_p1  = pos_reg + CNT_W'(1);
    assign cnt_ext = {5'd0, cnt_reg};
    assign pos_ext = {4'd0, pos_reg};

    // Slot memory
    dlts_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_TASKS)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_bits)
    );

    // Read address select
    always_comb
    begin
        case (cmd.rd_sel)
            dlts_pkg::RD_ZERO: rd_addr = '0;
            dlts_pkg::RD_POS:  rd_addr = pos_reg[AW-1:0];
            dlts_pkg::RD_KM1:  rd_addr = k_m1[AW-1:0];
            dlts_pkg::RD_KM2:  rd_addr = k_m2[AW-1:0];
            dlts_pkg::RD_KP1:  rd_addr = k_p1[AW-1:0];
            dlts_pkg::RD_KP2:  rd_addr = k_p2[AW-1:0];
            default:           rd_addr = '0;
        endcase
    end

    // Head update on a tick: count down, or bump pending at zero
    always_comb
    begin
        tick_entry = rd_entry;
        if (rd_entry.delay == 32'd0)
        begin
            if (rd_entry.pending != dlts_pkg::PENDING_MAX)
            begin
                tick_entry.pending = rd_entry.pending + 8'd1;
            end
        end
        else
        begin
            tick_entry.delay = rd_entry.delay - 32'd1;
        end
    end

    // Shifted entry; the new entry's follower loses the remaining delay
    always_comb
    begin
        sh_entry = rd_entry;
        if (k_reg == pos_p1)
        begin
            sh_entry.delay = rd_entry.delay - rem_reg;
        end
    end

    assign new_entry = '{tid: task_reg, delay: rem_reg, period: per_reg, pending: 8'd0};

    // Write address/data select
    assign wr_en = cmd.wr_en;
    always_comb
    begin
        case (cmd.wr_sel)
            dlts_pkg::WR_TICK:
            begin
                wr_addr  = '0;
                wr_entry = tick_entry;
            end
            dlts_pkg::WR_SHIFT:
            begin
                wr_addr  = k_reg[AW-1:0];
                wr_entry = sh_entry;
            end
            dlts_pkg::WR_MOVE:
            begin
                wr_addr  = k_reg[AW-1:0];
                wr_entry = rd_entry;
            end
            default:
            begin
                wr_addr  = pos_reg[AW-1:0];
                wr_entry = new_entry;
            end
        endcase
    end

    // Counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pos_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (cmd.cnt_dec)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end

            if (cmd.pos_clr)
            begin
                pos_reg <= '0;
            end
            else if (cmd.walk_step)
            begin
                pos_reg <= pos_p1;
            end

            if (cmd.k_load)
            begin
                k_reg <= cnt_reg;
            end
            else if (cmd.k_clr)
            begin
                k_reg <= '0;
            end
            else if (cmd.k_dec)
            begin
                k_reg <= k_m1;
            end
            else if (cmd.k_inc)
            begin
                k_reg <= k_p1;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg    <= in_data.req_type;
            task_reg   <= in_data.task_ident;
            rem_reg    <= in_data.first_delay;
            per_reg    <= in_data.repeat_period;
            fired_reg  <= 1'b0;
            ftask_reg  <= 8'd0;
            idx_reg    <= 4'd0;
            status_reg <= 1'b0;
        end
        else
        begin
            if (cmd.walk_step)
            begin
                rem_reg <= rem_reg - rd_entry.delay;
            end
            if (cmd.fire)
            begin
                fired_reg <= 1'b1;
                ftask_reg <= rd_entry.tid;
                task_reg  <= rd_entry.tid;
                rem_reg   <= rd_entry.period;
                per_reg   <= rd_entry.period;
            end
            if (cmd.set_full)
            begin
                status_reg <= 1'b1;
            end
            if (cmd.set_index)
            begin
                idx_reg <= pos_ext[3:0];
            end
        end

        if (cmd.out_load)
        begin
            out_data_reg.fired        <= fired_reg;
            out_data_reg.fired_task   <= ftask_reg;
            out_data_reg.insert_index <= idx_reg;
            out_data_reg.status       <= status_reg;
            out_data_reg.entries_used <= cnt_ext[4:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Status to controller
    always_comb
    begin
        stat.req          = req_reg;
        stat.cnt_zero     = (cnt_reg == '0);
        stat.full         = (cnt_reg == CNT_W'(MAX_TASKS));
        stat.walk_end     = (pos_reg == cnt_reg);
        stat.walk_go      = (rem_reg >= rd_entry.delay);
        stat.k_above_pos  = (k_reg > pos_reg);
        stat.k_above_pos1 = ({1'b0, k_reg} > ({1'b0, pos_reg} + (CNT_W+1)'(1)));
        stat.rm_more      = (({1'b0, k_reg} + (CNT_W+1)'(1)) < {1'b0, cnt_reg});
        stat.rm_more2     = (({1'b0, k_reg} + (CNT_W+1)'(2)) < {1'b0, cnt_reg});
        stat.pending_nz   = (rd_entry.pending != 8'd0);
        stat.per_nz       = (per_reg != 32'd0);
        stat.out_free     = !out_valid_reg || out_ready;
    end

`ifndef NO_ASSERTIONS
    // List never holds more than its capacity
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_TASKS))
        else $error("list count above capacity");

    // Walk reads stay within the list
    a_pos_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_en && cmd.rd_sel == dlts_pkg::RD_POS) |-> (pos_reg < cnt_reg))
        else $error("walk read past end of list");

    // Inserting a new entry requires a free slot
    a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && cmd.wr_sel == dlts_pkg::WR_NEW) |-> (cnt_reg < CNT_W'(MAX_TASKS)))
        else $error("insert into full list");

    // A result is never loaded over one still waiting
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten");
`endif

endmodule

// File: rtl/delta_list_task_scheduler_top.sv
// Per item: a tick updates the head entry (nothing on an empty list); an add
// walks to its insert place (P), shifts the tail up and inserts, or only sets
// the status when full; a dispatch fires the head if it has runs pending and
// removes it, and a periodic task goes back in through walk, shift and insert.
// One item at a time: a new item is taken only when the last one is done, and
// a waiting result holds off the next one. Reset (rst_n, async,
// active low) empties the list; slot memory is not cleared.
module delta_list_task_scheduler_top #(
    parameter int MAX_TASKS = dlts_pkg::DEFAULT_MAX_TASKS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dlts_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output dlts_pkg::out_item_t out_data
);

    dlts_pkg::dlts_cmd_t  cmd;
    dlts_pkg::dlts_stat_t stat;

    // Sequencer
    dlts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage and arithmetic
    dlts_dpath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
